// ===== hw/rtl/fwhw_pkg.sv =====
// fwhw_pkg: shared types, mode codes and the two fullwidth character tables
// of the fullwidth-to-halfwidth decoder
// no dependencies
package fwhw_pkg;

  // encoding modes, code 3 behaves as passthrough
  localparam logic [1:0] MODE_UTF8  = 2'd0;
  localparam logic [1:0] MODE_EUCJP = 2'd1;
  localparam logic [1:0] MODE_PASS  = 2'd2;

  localparam int TABLE_SIZE = 95;
  localparam int IDX_W      = 7;
  localparam int GRP_CNT_W  = 3;
  localparam logic [7:0] ASCII_BASE = 8'h20;

  // control part of one result group handed to the output serializer
  typedef struct packed {
    logic [GRP_CNT_W-1:0] cnt;  // number of result bytes, 0 means none
    logic                 has;  // 0 only on an end marker
    logic                 eos;  // group closes the string
  } fwhw_grp_t;

  localparam logic [23:0] UTF8_TABLE [TABLE_SIZE] = '{
    24'hE38080, 24'hEFBC81, 24'hE2809D, 24'hEFBC83, 24'hEFBC84, 24'hEFBC85, 24'hEFBC86,
    24'hE28099, 24'hEFBC88, 24'hEFBC89, 24'hEFBC8A, 24'hEFBC8B, 24'hEFBC8C, 24'hEFBC8D,
    24'hEFBC8E, 24'hEFBC8F, 24'hEFBC90, 24'hEFBC91, 24'hEFBC92, 24'hEFBC93, 24'hEFBC94,
    24'hEFBC95, 24'hEFBC96, 24'hEFBC97, 24'hEFBC98, 24'hEFBC99, 24'hEFBC9A, 24'hEFBC9B,
    24'hEFBC9C, 24'hEFBC9D, 24'hEFBC9E, 24'hEFBC9F, 24'hEFBCA0, 24'hEFBCA1, 24'hEFBCA2,
    24'hEFBCA3, 24'hEFBCA4, 24'hEFBCA5, 24'hEFBCA6, 24'hEFBCA7, 24'hEFBCA8, 24'hEFBCA9,
    24'hEFBCAA, 24'hEFBCAB, 24'hEFBCAC, 24'hEFBCAD, 24'hEFBCAE, 24'hEFBCAF, 24'hEFBCB0,
    24'hEFBCB1, 24'hEFBCB2, 24'hEFBCB3, 24'hEFBCB4, 24'hEFBCB5, 24'hEFBCB6, 24'hEFBCB7,
    24'hEFBCB8, 24'hEFBCB9, 24'hEFBCBA, 24'hEFBCBB, 24'hEFBFA5, 24'hEFBCBD, 24'hEFBCBE,
    24'hEFBCBF, 24'hE28098, 24'hEFBD81, 24'hEFBD82, 24'hEFBD83, 24'hEFBD84, 24'hEFBD85,
    24'hEFBD86, 24'hEFBD87, 24'hEFBD88, 24'hEFBD89, 24'hEFBD8A, 24'hEFBD8B, 24'hEFBD8C,
    24'hEFBD8D, 24'hEFBD8E, 24'hEFBD8F, 24'hEFBD90, 24'hEFBD91, 24'hEFBD92, 24'hEFBD93,
    24'hEFBD94, 24'hEFBD95, 24'hEFBD96, 24'hEFBD97, 24'hEFBD98, 24'hEFBD99, 24'hEFBD9A,
    24'hEFBD9B, 24'hEFBD9C, 24'hEFBD9D, 24'hEFBD9E
  };

  localparam logic [15:0] EUCJP_TABLE [TABLE_SIZE] = '{
    16'hA1A1, 16'hA1AA, 16'hA1C9, 16'hA1F4, 16'hA1F0, 16'hA1F3, 16'hA1F5, 16'hA1C7,
    16'hA1CA, 16'hA1CB, 16'hA1F6, 16'hA1DC, 16'hA1A4, 16'hA1DD, 16'hA1A5, 16'hA1BF,
    16'hA3B0, 16'hA3B1, 16'hA3B2, 16'hA3B3, 16'hA3B4, 16'hA3B5, 16'hA3B6, 16'hA3B7,
    16'hA3B8, 16'hA3B9, 16'hA1A7, 16'hA1A8, 16'hA1E3, 16'hA1E1, 16'hA1E4, 16'hA1A9,
    16'hA1F7, 16'hA3C1, 16'hA3C2, 16'hA3C3, 16'hA3C4, 16'hA3C5, 16'hA3C6, 16'hA3C7,
    16'hA3C8, 16'hA3C9, 16'hA3CA, 16'hA3CB, 16'hA3CC, 16'hA3CD, 16'hA3CE, 16'hA3CF,
    16'hA3D0, 16'hA3D1, 16'hA3D2, 16'hA3D3, 16'hA3D4, 16'hA3D5, 16'hA3D6, 16'hA3D7,
    16'hA3D8, 16'hA3D9, 16'hA3DA, 16'hA1CE, 16'hA1EF, 16'hA1CF, 16'hA1B0, 16'hA1B2,
    16'hA1C6, 16'hA3E1, 16'hA3E2, 16'hA3E3, 16'hA3E4, 16'hA3E5, 16'hA3E6, 16'hA3E7,
    16'hA3E8, 16'hA3E9, 16'hA3EA, 16'hA3EB, 16'hA3EC, 16'hA3ED, 16'hA3EE, 16'hA3EF,
    16'hA3F0, 16'hA3F1, 16'hA3F2, 16'hA3F3, 16'hA3F4, 16'hA3F5, 16'hA3F6, 16'hA3F7,
    16'hA3F8, 16'hA3F9, 16'hA3FA, 16'hA1D0, 16'hA1C3, 16'hA1D1, 16'hA1C1
  };

endpackage

// ===== hw/rtl/fwhw_match.sv =====
// fwhw_match: parallel compare of one gathered character against the
// fullwidth table, first hit wins
// depends on fwhw_pkg
module fwhw_match import fwhw_pkg::*; #(
  parameter int TABLE_ENTRIES = 95
) (
  input  logic             en_i,    // length fits the table of this mode
  input  logic             utf_i,   // 1 utf-8 table, 0 euc-jp table
  input  logic [23:0]      key_i,   // first byte in the top bits
  output logic             hit_o,
  output logic [IDX_W-1:0] idx_o
);

  logic [TABLE_ENTRIES-1:0] hit;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (utf_i) begin
        hit[i] = (key_i == UTF8_TABLE[i]);
      end else begin
        hit[i] = (key_i[23:8] == EUCJP_TABLE[i]);
      end
    end
  end

  // lowest index wins
  always_comb begin
    idx_o = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        idx_o = IDX_W'(i);
      end
    end
    hit_o = en_i && (|hit);
  end

endmodule

// ===== hw/rtl/fwhw_conv.sv =====
// fwhw_conv: per-string state and the single-pass conversion of one byte
// into a result group of up to MAX_CHAR_BYTES bytes
// depends on fwhw_pkg and fwhw_match
module fwhw_conv import fwhw_pkg::*; #(
  parameter int TABLE_ENTRIES  = 95,
  parameter int MAX_CHAR_BYTES = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     mode_i,
  input  logic                           adv_i,
  input  logic [7:0]                     byte_i,
  input  logic                           eos_i,
  output fwhw_grp_t                      grp_o,
  output logic [MAX_CHAR_BYTES-1:0][7:0] bytes_o
);

  localparam int CW = $clog2(MAX_CHAR_BYTES + 1);
  localparam int IW = $clog2(MAX_CHAR_BYTES);

  logic [MAX_CHAR_BYTES-1:0][7:0] char_q, ins;
  logic [CW-1:0] len_q, len_d, gat_q, gat_d, gat_inc, lead, g_cnt;
  logic          stop_q, stop_d;
  logic          conv, utf, single, emit_g, m_en, m_hit;
  logic [7:0]    single_byte;
  logic [2:0]    raw_lead;
  logic [IDX_W-1:0] m_idx;

  function automatic logic [2:0] lead_len(logic utf8, logic [7:0] b);
    logic [2:0] l;
    l = 3'd1;
    if (utf8) begin
      if (b[7:5] == 3'b110) begin
        l = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        l = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
        l = 3'd4;
      end
    end else begin
      if (b == 8'h8F) begin
        l = 3'd3;
      end else if (b[7]) begin
        l = 3'd2;
      end
    end
    return l;
  endfunction

  assign conv     = (mode_i == MODE_UTF8) || (mode_i == MODE_EUCJP);
  assign utf      = (mode_i == MODE_UTF8);
  assign raw_lead = lead_len(utf, byte_i);
  assign lead     = (raw_lead > 3'(MAX_CHAR_BYTES)) ? CW'(MAX_CHAR_BYTES) : CW'(raw_lead);
  assign gat_inc  = gat_q + CW'(1);

  // byte store with the incoming byte in its slot
  always_comb begin
    ins = char_q;
    if (len_q == '0) begin
      ins[0] = byte_i;
    end else begin
      ins[gat_q[IW-1:0]] = byte_i;
    end
  end

  assign m_en = (len_q == (utf ? CW'(3) : CW'(2)));

  fwhw_match #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_match (
    .en_i (m_en),
    .utf_i(utf),
    .key_i({ins[0], ins[1], ins[2]}),
    .hit_o(m_hit),
    .idx_o(m_idx)
  );

  always_comb begin
    len_d       = len_q;
    gat_d       = gat_q;
    stop_d      = stop_q;
    single      = 1'b0;
    single_byte = byte_i;
    emit_g      = 1'b0;
    if (!conv) begin
      single = 1'b1;
    end else if (stop_q) begin
      // rest of the string is dropped
    end else if (len_q == '0) begin
      if (byte_i == 8'h00) begin
        stop_d = 1'b1;
      end else if (lead == CW'(1)) begin
        single = 1'b1;
      end else begin
        len_d = lead;
        gat_d = CW'(1);
      end
    end else begin
      gat_d = gat_inc;
      if (gat_inc >= len_q) begin
        if (m_hit) begin
          single      = 1'b1;
          single_byte = 8'(ASCII_BASE + 8'(m_idx));
          len_d       = '0;
          gat_d       = '0;
        end else begin
          emit_g = 1'b1;
        end
      end
    end
    // string cut short while a character is open
    if (eos_i && (len_d != '0)) begin
      emit_g = 1'b1;
    end
    g_cnt = gat_d;
    if (emit_g || eos_i) begin
      len_d = '0;
      gat_d = '0;
    end
    if (eos_i) begin
      stop_d = 1'b0;
    end

    bytes_o   = ins;
    grp_o.eos = eos_i;
    grp_o.has = 1'b1;
    if (single) begin
      grp_o.cnt  = GRP_CNT_W'(1);
      bytes_o[0] = single_byte;
    end else if (emit_g) begin
      grp_o.cnt = GRP_CNT_W'(g_cnt);
    end else if (eos_i) begin
      grp_o.cnt  = GRP_CNT_W'(1);
      grp_o.has  = 1'b0;
      bytes_o[0] = 8'h00;
    end else begin
      grp_o.cnt = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      gat_q  <= '0;
      stop_q <= 1'b0;
    end else if (cfg_we_i) begin
      len_q  <= '0;
      gat_q  <= '0;
      stop_q <= 1'b0;
    end else if (adv_i) begin
      len_q  <= len_d;
      gat_q  <= gat_d;
      stop_q <= stop_d;
    end
  end

  // entries past the gathered count are never read
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      char_q <= ins;
    end
  end

endmodule

// ===== hw/rtl/fwhw_burst.sv =====
// fwhw_burst: result group register that sends its bytes one transfer
// per cycle on the output stream while the output is ready
// depends on fwhw_pkg
module fwhw_burst import fwhw_pkg::*; #(
  parameter int MAX_CHAR_BYTES = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  fwhw_grp_t                      grp_i,
  input  logic [MAX_CHAR_BYTES-1:0][7:0] bytes_i,
  output logic                           ready_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [7:0]                     m_axis_tdata_o,
  output logic [1:0]                     m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);

  localparam int IW = $clog2(MAX_CHAR_BYTES);

  logic                           vld_q;
  logic [MAX_CHAR_BYTES-1:0][7:0] bytes_q;
  fwhw_grp_t                      grp_q;
  logic [GRP_CNT_W-1:0]           beat_q;
  logic                           last_beat, take;

  assign last_beat = ((beat_q + GRP_CNT_W'(1)) == grp_q.cnt);
  assign take      = vld_q && m_axis_tready_i;
  assign ready_o   = !vld_q || (take && last_beat);

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = bytes_q[beat_q[IW-1:0]];
  assign m_axis_tuser_o  = {last_beat, grp_q.has};
  assign m_axis_tlast_o  = last_beat && grp_q.eos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      beat_q <= '0;
    end else if (load_i && ready_o) begin
      vld_q  <= (grp_i.cnt != '0);
      beat_q <= '0;
    end else if (take) begin
      if (last_beat) begin
        vld_q <= 1'b0;
      end
      beat_q <= beat_q + GRP_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      bytes_q <= bytes_i;
      grp_q   <= grp_i;
    end
  end

endmodule

// ===== hw/rtl/fullwidth_to_halfwidth_decoder_core.sv =====
// fullwidth_to_halfwidth_decoder_core: top level of the fullwidth-to-halfwidth
// decoder, input register, mode register and the two datapath parts
// depends on fwhw_pkg, fwhw_conv, fwhw_match and fwhw_burst
//
// Converts a text stream, one byte per input transfer, from fullwidth
// punctuation, digits and letters to printable ascii. The mode register
// (cfg_wdata_i, reset passthrough) picks utf-8 (0), euc-jp (1) or passthrough
// (2, and 3 acts the same); a write also drops any open character and starts
// a fresh string, so write it only while the block is idle. In a conversion
// mode a multibyte character is gathered, looked up in a fixed table and sent
// as 0x20 plus its table index, or sent unchanged when it has no match. A nul
// lead byte drops the rest of the string. s_axis_tlast_i marks the last byte
// of a string; a character cut short there comes out as the bytes received.
// An input byte causes zero to MAX_CHAR_BYTES output transfers. A string end
// that causes no byte gives one end marker with has_byte low and a zero byte.
// Datapath: a byte passes an input register and one pass of logic into the
// result group register, which the output serializer sends from. The input
// takes one byte per cycle while each byte causes at most one result and the
// output is ready; a byte with more results holds the serializer until its
// last result is taken, and the input waits behind it.
module fullwidth_to_halfwidth_decoder_core import fwhw_pkg::*; #(
  parameter int TABLE_ENTRIES  = 95,
  parameter int MAX_CHAR_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // mode register write
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // end_of_string
  // result stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,   // [0] has_byte, [1] last_of_run
  output logic       m_axis_tlast_o    // string_done
);

  logic [1:0]  mode_q;
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_eos_q;
  logic        adv, grp_ready;
  fwhw_grp_t   grp;
  logic [MAX_CHAR_BYTES-1:0][7:0] grp_bytes;

  // the held byte moves on once the serializer can take its group
  assign adv             = in_vld_q && grp_ready;
  assign s_axis_tready_o = !in_vld_q || adv;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PASS;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_eos_q  <= s_axis_tlast_i;
    end
  end

  // string state, table match and result group
  fwhw_conv #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CHAR_BYTES(MAX_CHAR_BYTES)
  ) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_we_i(cfg_we_i),
    .mode_i  (mode_q),
    .adv_i   (adv),
    .byte_i  (in_byte_q),
    .eos_i   (in_eos_q),
    .grp_o   (grp),
    .bytes_o (grp_bytes)
  );

  // result group register and output serializer
  fwhw_burst #(
    .MAX_CHAR_BYTES(MAX_CHAR_BYTES)
  ) u_burst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (adv),
    .grp_i          (grp),
    .bytes_i        (grp_bytes),
    .ready_o        (grp_ready),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule
